### src/sbfd_pkg.sv
// sbfd_pkg: shared types and constants for the sync byte frame deframer
// no dependencies; imported by the front, queue, back and top modules
`timescale 1ns / 1ps
`default_nettype none

package sbfd_pkg;

	// sync pair: header bytes 0 and 1
	localparam logic [7:0] SYNC_FIRST  = 8'h81;
	localparam logic [7:0] SYNC_SECOND = 8'h40;

	// result kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;
	localparam logic [1:0] KIND_ABORT = 2'd3;

	// byte positions within a frame
	localparam logic [9:0] POS_RESTART = 10'd2;
	localparam logic [9:0] POS_TYPE    = 10'd4;
	localparam logic [9:0] POS_COUNT   = 10'd5;
	localparam logic [9:0] POS_EA_LO   = 10'd6;
	localparam logic [9:0] POS_EA_HI   = 10'd7;
	localparam logic [9:0] POS_SA_LO   = 10'd8;
	localparam logic [9:0] POS_SA_HI   = 10'd9;
	localparam logic [9:0] POS_CK_LO   = 10'd10;
	localparam logic [9:0] POS_CK_HI   = 10'd11;
	localparam logic [9:0] POS_PAYLOAD = 10'd12;

	// one classified byte handed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       sync;
	} sbfd_item_t;

endpackage

`default_nettype wire

### src/sync_byte_frame_deframer_top.sv
// sync_byte_frame_deframer_top: byte stream in, one result beat per byte out
// depends on sbfd_pkg, sbfd_front, sbfd_queue and sbfd_back
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// in        input      in_valid / in_ready    rx_byte
// out       output     out_valid / out_ready  kind, payload_byte, payload_index,
//                                             frame_type, sample_count, start_angle,
//                                             end_angle, frame_checksum
//
// one input beat per cycle sustained while the output is not stalled, exactly one output beat per input beat
// each byte passes through the classifier queue, then through the result register
// in_ready drops only while the QUEUE_DEPTH-entry queue is full
// arst_n clears the frame state, queue pointers and the previous-byte register
// a stalled output holds its beat; the queue soaks up input until it fills

module sync_byte_frame_deframer_top import sbfd_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       payload_byte,
	output logic [8:0]       payload_index,
	output logic [7:0]       frame_type,
	output logic [7:0]       sample_count,
	output logic [15:0]      start_angle,
	output logic [15:0]      end_angle,
	output logic [15:0]      frame_checksum
);

	// front to queue
	logic       push;
	sbfd_item_t push_item;
	logic       q_full;

	// queue to back
	logic       pop;
	logic       q_avail;
	sbfd_item_t pop_item;

	// front: tracks the previous byte and marks the second byte of a sync pair
	sbfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.push     (push),
		.item     (push_item)
	);

	// queue: decouples byte intake from result delivery
	sbfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (push_item),
		.full     (q_full),
		.pop      (pop),
		.avail    (q_avail),
		.item_out (pop_item)
	);

	// back: header, extras and payload sequencing, result register
	sbfd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.avail          (q_avail),
		.item           (pop_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.frame_type     (frame_type),
		.sample_count   (sample_count),
		.start_angle    (start_angle),
		.end_angle      (end_angle),
		.frame_checksum (frame_checksum)
	);

endmodule

`default_nettype wire

### src/sbfd_front.sv
// sbfd_front: accepts received bytes and flags the second byte of a sync pair
// depends on sbfd_pkg; feeds sbfd_queue
`timescale 1ns / 1ps
`default_nettype none

module sbfd_front import sbfd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       q_full,
	output logic            push,
	output sbfd_item_t      item
);

	logic [7:0] prev_q;

	assign in_ready  = !q_full;
	assign push      = in_valid && in_ready;
	assign item.data = rx_byte;
	assign item.sync = (prev_q == SYNC_FIRST) && (rx_byte == SYNC_SECOND);

	// byte of the previous beat, kept whatever the frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (push) begin
			prev_q <= rx_byte;
		end
	end

endmodule

`default_nettype wire

### src/sbfd_queue.sv
// sbfd_queue: short fifo of classified bytes between front and back
// depends on sbfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbfd_queue import sbfd_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire sbfd_item_t item_in,
	output logic            full,
	input  wire logic       pop,
	output logic            avail,
	output sbfd_item_t      item_out
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	sbfd_item_t      mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign full     = (cnt_q == FULL_CNT);
	assign avail    = (cnt_q != '0);
	assign item_out = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!avail |-> !pop)
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

### src/sbfd_back.sv
// sbfd_back: frame state machine and registered result beat
// depends on sbfd_pkg; drains sbfd_queue
`timescale 1ns / 1ps
`default_nettype none

module sbfd_back import sbfd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        avail,
	input  wire sbfd_item_t  item,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       payload_byte,
	output logic [8:0]       payload_index,
	output logic [7:0]       frame_type,
	output logic [7:0]       sample_count,
	output logic [15:0]      start_angle,
	output logic [15:0]      end_angle,
	output logic [15:0]      frame_checksum
);

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_HEAD    = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	logic [1:0]  ph_q, ph_n;
	logic [9:0]  pos_q, pos_n;
	logic [7:0]  ht_q, ht_n;
	logic [7:0]  hc_q, hc_n;
	logic [15:0] ea_q, ea_n;
	logic [15:0] sa_q, sa_n;
	logic [15:0] ck_q, ck_n;

	logic        out_valid_q;
	logic [1:0]  kind_q, kind_n;
	logic [7:0]  pb_q, pb_n;
	logic [8:0]  pi_q, pi_n;
	logic [7:0]  ft_q, ft_n;
	logic [7:0]  sc_q, sc_n;
	logic [15:0] sa_out_q, sa_out_n;
	logic [15:0] ea_out_q, ea_out_n;
	logic [15:0] ck_out_q, ck_out_n;

	logic [9:0]  idx;
	logic [8:0]  total;
	logic        last;

	assign pop = avail && (!out_valid_q || out_ready);

	assign idx   = pos_q - POS_PAYLOAD;
	assign total = {hc_q, 1'b0};
	assign last  = ({1'b0, idx} + 11'd1) >= {2'b00, total};

	always_comb begin
		ph_n     = ph_q;
		pos_n    = pos_q;
		ht_n     = ht_q;
		hc_n     = hc_q;
		ea_n     = ea_q;
		sa_n     = sa_q;
		ck_n     = ck_q;
		kind_n   = KIND_NONE;
		pb_n     = '0;
		pi_n     = '0;
		ft_n     = '0;
		sc_n     = '0;
		sa_out_n = '0;
		ea_out_n = '0;
		ck_out_n = '0;

		if (ph_q != PH_HEAD && ph_q != PH_PAYLOAD) begin
			ph_n = PH_HUNT;
			if (item.sync) begin
				ph_n  = PH_HEAD;
				pos_n = POS_RESTART;
				ht_n  = '0;
				hc_n  = '0;
				ea_n  = '0;
				sa_n  = '0;
				ck_n  = '0;
			end
		end else if (item.sync) begin
			// resync inside a frame: report what was held, then restart
			kind_n   = KIND_ABORT;
			ft_n     = ht_q;
			sc_n     = hc_q;
			sa_out_n = sa_q;
			ea_out_n = ea_q;
			ck_out_n = ck_q;
			ph_n     = PH_HEAD;
			pos_n    = POS_RESTART;
			ht_n     = '0;
			hc_n     = '0;
			ea_n     = '0;
			sa_n     = '0;
			ck_n     = '0;
		end else if (ph_q == PH_HEAD) begin
			case (pos_q)
				POS_TYPE:  ht_n = item.data;
				POS_COUNT: hc_n = item.data;
				POS_EA_LO: ea_n = {ea_q[15:8], item.data};
				POS_EA_HI: ea_n = {item.data, ea_q[7:0]};
				POS_SA_LO: sa_n = {sa_q[15:8], item.data};
				POS_SA_HI: sa_n = {item.data, sa_q[7:0]};
				POS_CK_LO: ck_n = {ck_q[15:8], item.data};
				POS_CK_HI: ck_n = {item.data, ck_q[7:0]};
				default:   ;
			endcase
			if (pos_q >= POS_CK_HI) begin
				if (hc_n == '0) begin
					// empty payload ends on the last extra byte
					kind_n   = KIND_DONE;
					ft_n     = ht_n;
					sc_n     = hc_n;
					sa_out_n = sa_n;
					ea_out_n = ea_n;
					ck_out_n = ck_n;
					ph_n     = PH_HUNT;
					pos_n    = '0;
				end else begin
					ph_n  = PH_PAYLOAD;
					pos_n = POS_PAYLOAD;
				end
			end else begin
				pos_n = pos_q + 10'd1;
			end
		end else begin
			pb_n     = item.data;
			pi_n     = idx[8:0];
			ft_n     = ht_q;
			sc_n     = hc_q;
			sa_out_n = sa_q;
			ea_out_n = ea_q;
			ck_out_n = ck_q;
			if (last) begin
				kind_n = KIND_DONE;
				ph_n   = PH_HUNT;
				pos_n  = '0;
			end else begin
				kind_n = KIND_DATA;
				pos_n  = pos_q + 10'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_HUNT;
			pos_q       <= '0;
			ht_q        <= '0;
			hc_q        <= '0;
			ea_q        <= '0;
			sa_q        <= '0;
			ck_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				ph_q  <= ph_n;
				pos_q <= pos_n;
				ht_q  <= ht_n;
				hc_q  <= hc_n;
				ea_q  <= ea_n;
				sa_q  <= sa_n;
				ck_q  <= ck_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= kind_n;
			pb_q     <= pb_n;
			pi_q     <= pi_n;
			ft_q     <= ft_n;
			sc_q     <= sc_n;
			sa_out_q <= sa_out_n;
			ea_out_q <= ea_out_n;
			ck_out_q <= ck_out_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign payload_byte   = pb_q;
	assign payload_index  = pi_q;
	assign frame_type     = ft_q;
	assign sample_count   = sc_q;
	assign start_angle    = sa_out_q;
	assign end_angle      = ea_out_q;
	assign frame_checksum = ck_out_q;

	a_none_is_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_NONE) |->
		(payload_byte == '0 && payload_index == '0 && frame_type == '0 &&
		sample_count == '0 && start_angle == '0 && end_angle == '0 &&
		frame_checksum == '0))
		else $error("empty result carries data");

	a_abort_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_ABORT) |->
		(payload_byte == '0 && payload_index == '0))
		else $error("abort result carries a payload byte");

	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_DATA) |->
		({1'b0, payload_index} + 10'd1 < {1'b0, sample_count, 1'b0}))
		else $error("payload index past end of frame");

	a_resync_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && item.sync) |=> (ph_q == PH_HEAD && pos_q == POS_RESTART))
		else $error("sync pair did not restart the frame");

endmodule

`default_nettype wire

### test/sync_byte_frame_deframer_top_tb.sv
// sync_byte_frame_deframer_top_tb: self-checking bench for the sync byte frame deframer
// depends on sbfd_pkg and sync_byte_frame_deframer_top; byte beats in, result beats checked
`timescale 1ns / 1ps

module sync_byte_frame_deframer_top_tb;
	import sbfd_pkg::*;

	localparam int CYCLE_LIMIT      = 200000;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES     = 10;

	// hunting, header plus extra words, payload
	typedef enum logic [1:0] {
		PHASE_HUNT,
		PHASE_HEADER,
		PHASE_PAYLOAD
	} frame_phase_t;

	// one result beat, field for field as the ports carry it
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [8:0]  payload_index;
		logic [7:0]  frame_type;
		logic [7:0]  sample_count;
		logic [15:0] start_angle;
		logic [15:0] end_angle;
		logic [15:0] frame_checksum;
	} deframe_result_t;

	typedef logic [7:0] byte_stream_t[$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [8:0]  payload_index;
	logic [7:0]  frame_type;
	logic [7:0]  sample_count;
	logic [15:0] start_angle;
	logic [15:0] end_angle;
	logic [15:0] frame_checksum;

	// idle percentages for each side, changed per test phase
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic receiver_held = 1'b0;
	event long_hold_start;

	int bytes_sent = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	// results still owed by the block, oldest first
	deframe_result_t expected_results[$];

	// deframer state as the bench tracks it
	frame_phase_t frame_phase = PHASE_HUNT;
	logic [7:0]   last_byte = 8'h00;
	logic [9:0]   frame_pos = '0;
	logic [7:0]   held_type = '0;
	logic [7:0]   held_count = '0;
	logic [15:0]  held_end = '0;
	logic [15:0]  held_start = '0;
	logic [15:0]  held_sum = '0;

	sync_byte_frame_deframer_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.frame_type     (frame_type),
		.sample_count   (sample_count),
		.start_angle    (start_angle),
		.end_angle      (end_angle),
		.frame_checksum (frame_checksum)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// a sync pair opens a frame at header byte 2 with everything held cleared
	function automatic void open_frame();
		frame_phase = PHASE_HEADER;
		frame_pos   = POS_RESTART;
		held_type   = '0;
		held_count  = '0;
		held_end    = '0;
		held_start  = '0;
		held_sum    = '0;
	endfunction

	// result carrying the current frame's held header fields
	function automatic deframe_result_t frame_result(input logic [1:0] k);
		deframe_result_t r;
		r = '0;
		r.kind           = k;
		r.frame_type     = held_type;
		r.sample_count   = held_count;
		r.start_angle    = held_start;
		r.end_angle      = held_end;
		r.frame_checksum = held_sum;
		return r;
	endfunction

	// advance the deframer by one byte and return the beat it must give out
	function automatic deframe_result_t deframe_byte(input logic [7:0] b);
		deframe_result_t r;
		logic            sync_seen;
		logic [9:0]      pos;
		logic [9:0]      idx;
		logic [9:0]      total;
		r         = '0;
		sync_seen = (last_byte == SYNC_FIRST) && (b == SYNC_SECOND);
		pos       = frame_pos;
		last_byte = b;

		// while hunting only a sync pair matters, and it gives nothing out
		if (frame_phase == PHASE_HUNT) begin
			if (sync_seen)
				open_frame();
			return r;
		end

		// sync inside an open frame aborts it and opens the next one
		if (sync_seen) begin
			r = frame_result(KIND_ABORT);
			open_frame();
			return r;
		end

		if (frame_phase == PHASE_HEADER) begin
			case (pos)
				POS_TYPE: begin
					held_type = b;
				end
				POS_COUNT: begin
					held_count = b;
				end
				POS_EA_LO: begin
					held_end[7:0] = b;
				end
				POS_EA_HI: begin
					held_end[15:8] = b;
				end
				POS_SA_LO: begin
					held_start[7:0] = b;
				end
				POS_SA_HI: begin
					held_start[15:8] = b;
				end
				POS_CK_LO: begin
					held_sum[7:0] = b;
				end
				POS_CK_HI: begin
					held_sum[15:8] = b;
				end
				default: begin
				end
			endcase
			pos = pos + 10'd1;
			if (pos >= POS_PAYLOAD) begin
				// a frame with no samples completes on its last extra byte
				if (held_count == 8'd0) begin
					r           = frame_result(KIND_DONE);
					frame_phase = PHASE_HUNT;
					frame_pos   = '0;
				end else begin
					frame_phase = PHASE_PAYLOAD;
					frame_pos   = POS_PAYLOAD;
				end
			end else begin
				frame_pos = pos;
			end
			return r;
		end

		// payload: two bytes per sample, the last one closes the frame
		idx   = pos - POS_PAYLOAD;
		total = {1'b0, held_count, 1'b0};
		if (idx + 10'd1 >= total) begin
			r           = frame_result(KIND_DONE);
			frame_phase = PHASE_HUNT;
			frame_pos   = '0;
		end else begin
			r         = frame_result(KIND_DATA);
			frame_pos = pos + 10'd1;
		end
		r.payload_byte  = b;
		r.payload_index = idx[8:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// monitor: predict on each accepted byte beat, check each result beat
	// ------------------------------------------------------------------

	function automatic void compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : result_monitor
		deframe_result_t want;
		if (arst_n) begin
			// byte beat first, so the expectation is queued before any result is matched
			if (in_valid && in_ready)
				expected_results.push_back(deframe_byte(rx_byte));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no byte beat waiting for it");
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("kind", 16'(want.kind), 16'(kind));
					compare_field("payload_byte", 16'(want.payload_byte),
						16'(payload_byte));
					compare_field("payload_index", 16'(want.payload_index),
						16'(payload_index));
					compare_field("frame_type", 16'(want.frame_type), 16'(frame_type));
					compare_field("sample_count", 16'(want.sample_count),
						16'(sample_count));
					compare_field("start_angle", want.start_angle, start_angle);
					compare_field("end_angle", want.end_angle, end_angle);
					compare_field("frame_checksum", want.frame_checksum, frame_checksum);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver side: random stalls plus one long hold
	// ------------------------------------------------------------------

	always @(negedge clk)
		out_ready <= !receiver_held && ($urandom_range(99) >= recv_idle_pct);

	// long hold counted here so the sender keeps pushing while the block fills
	always begin
		@(long_hold_start);
		receiver_held = 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		receiver_held = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------

	// offer one byte beat, with random idle cycles ahead of it, and wait until taken
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_stream(input byte_stream_t s);
		foreach (s[i])
			send_byte(s[i]);
	endtask

	// sender stops and waits until the block has answered every byte
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// whole frame with random content; a broken one is cut short somewhere after the sync pair
	task automatic send_random_frame(input int count, input bit broken);
		byte_stream_t s;
		int           cut;
		s = {SYNC_FIRST, SYNC_SECOND};
		repeat (3) s.push_back(8'($urandom_range(255)));
		s.push_back(8'(count));
		repeat (6 + 2 * count) s.push_back(8'($urandom_range(255)));
		if (broken) begin
			cut = $urandom_range(s.size() - 1, 3);
			s = s[0:cut - 1];
		end
		send_stream(s);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// a lone 0x40 with no 0x81 ahead of it must not open a frame
	task automatic test_hunt_noise();
		send_stream('{SYNC_SECOND, 8'h00});
	endtask

	// frame aborted by a sync pair landing on its first extra byte; the 0x81 is taken
	// as the sample count first, so the abort beat carries it
	task automatic test_resync_abort();
		send_stream('{SYNC_FIRST, SYNC_SECOND, 8'h00, 8'hff, 8'h3c, SYNC_FIRST, SYNC_SECOND});
	endtask

	// rest of the frame the resync opened: no samples, so it completes on its last extra byte
	task automatic test_zero_count_frame();
		send_stream('{8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00, 8'h00, 8'ha5, 8'h5a});
	endtask

	// one sample: a payload byte beat then the frame complete beat
	task automatic test_single_sample_frame();
		send_stream('{SYNC_FIRST, SYNC_SECOND, 8'h12, 8'h34, 8'ha5, 8'h01,
			8'h00, 8'h80, 8'hff, 8'h7f, 8'h01, 8'hfe, 8'hc3, 8'h3c});
	endtask

	// receiver stalls for a long stretch while a frame streams in, so the input backs up
	task automatic test_receiver_backpressure();
		-> long_hold_start;
		send_random_frame(14, 1'b0);
		wait_for_results();
	endtask

	// mostly well-formed frames with small counts, some cut short, some line noise
	task automatic test_random_frames(input int items, input int send_pct, input int recv_pct);
		int stop_at;
		int pick;
		int count;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stop_at = bytes_sent + items;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				// noise with extra 0x81s so stray sync pairs show up
				repeat ($urandom_range(6, 1))
					send_byte(($urandom_range(3) == 0) ? SYNC_FIRST : 8'($urandom_range(255)));
			end else begin
				count = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(4);
				send_random_frame(count, pick < 25);
			end
		end
	endtask

	// largest count: payload index runs up to 509, the last of 510 payload bytes
	task automatic test_max_count_frame();
		send_random_frame(255, 1'b0);
		send_random_frame(0, 1'b0);
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 22;
		recv_idle_pct = 48;
		test_hunt_noise();
		test_resync_abort();
		test_zero_count_frame();
		test_single_sample_frame();
		wait_for_results();
		test_receiver_backpressure();

		test_random_frames(450, 22, 48);
		test_random_frames(450, 48, 22);
		test_random_frames(300, 0, 0);
		test_max_count_frame();

		wait_for_results();
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### sync_byte_frame_deframer_top.f
src/sbfd_pkg.sv
src/sbfd_front.sv
src/sbfd_queue.sv
src/sbfd_back.sv
src/sync_byte_frame_deframer_top.sv
test/sync_byte_frame_deframer_top_tb.sv
